// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define QBZ_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error(msg);

// expression must never be true outside reset
`define QBZ_NEVER(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error(msg);

`endif

// ----- hw/rtl/qbz_pkg.sv -----
// shared types and constants of the quadratic bezier segment generator
// no dependencies
package qbz_pkg;

	localparam int COORD_W = 32;
	localparam int RES_W   = 7;

	localparam logic [RES_W-1:0]   RES_RESET = 7'd50;
	localparam logic [COORD_W-1:0] SIGN_BIT  = 32'h8000_0000;

	// register select: address bit 2 picks the register word
	localparam logic REG_RESOLUTION = 1'b0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_RUN,
		ST_DRAIN
	} qbz_state_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic seg_step;
	} qbz_cmd_t;

	typedef struct packed {
		logic div_done;
		logic issue_last;
		logic adv;
		logic pipe_empty;
	} qbz_status_t;

endpackage

// ----- hw/rtl/qbz_in_if.sv -----
// input channel: one curve item with its control points
// depends on nothing
interface qbz_in_if;
	logic               valid;
	logic               ready;
	logic               mode;
	logic signed [31:0] p0_x;
	logic signed [31:0] p0_y;
	logic signed [31:0] p0_z;
	logic signed [31:0] p1_x;
	logic signed [31:0] p1_y;
	logic signed [31:0] p1_z;
	logic signed [31:0] p2_x;
	logic signed [31:0] p2_y;
	logic signed [31:0] p2_z;

	modport source (
		output valid, mode, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
		input  ready
	);
	modport sink (
		input  valid, mode, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
		output ready
	);
endinterface

// ----- hw/rtl/qbz_out_if.sv -----
// output channel: one line segment item
// depends on nothing
interface qbz_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] start_x;
	logic signed [31:0] start_y;
	logic signed [31:0] start_z;
	logic signed [31:0] end_x;
	logic signed [31:0] end_y;
	logic signed [31:0] end_z;
	logic               last_segment;

	modport source (
		output valid, start_x, start_y, start_z, end_x, end_y, end_z, last_segment,
		input  ready
	);
	modport sink (
		input  valid, start_x, start_y, start_z, end_x, end_y, end_z, last_segment,
		output ready
	);
endinterface

// ----- hw/rtl/qbz_ctrl.sv -----
// controller of the segment generator: sequences load, divide, segment issue and drain
// depends on qbz_pkg
module qbz_ctrl import qbz_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  qbz_status_t status,
	output qbz_cmd_t    cmd
);

	qbz_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		cmd.load     = 1'b0;
		cmd.div_step = 1'b0;
		cmd.seg_step = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DIV;
				end
			end
			ST_DIV: begin
				if (status.div_done) begin
					state_d = ST_RUN;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			ST_RUN: begin
				if (status.adv) begin
					cmd.seg_step = 1'b1;
					if (status.issue_last) begin
						state_d = ST_DRAIN;
					end
				end
			end
			ST_DRAIN: begin
				if (status.pipe_empty) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- hw/rtl/qbz_datapath.sv -----
// datapath of the segment generator: step divider, t stepping, weight and blend pipeline
// depends on qbz_pkg
module qbz_datapath import qbz_pkg::*; #(
	parameter int MAX_SEGMENTS  = 64,
	parameter int FRACTION_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  qbz_cmd_t                     cmd,
	output qbz_status_t                  status,
	input  logic [RES_W-1:0]             resolution,
	input  logic                         mode,
	input  logic [2:0][2:0][COORD_W-1:0] ctl_pts,
	input  logic                         out_ready,
	output logic                         out_valid,
	output logic [2:0][COORD_W-1:0]      seg_start,
	output logic [2:0][COORD_W-1:0]      seg_end,
	output logic                         seg_last
);

	localparam int F     = FRACTION_BITS;
	localparam int TW    = F + 1;
	localparam int WW    = 2 * F + 1;
	localparam int HW    = COORD_W / 2;
	localparam int AW    = 2 * F + HW;
	localparam int TOT_W = AW + HW;
	localparam int N_W   = $clog2(MAX_SEGMENTS + 1);
	localparam int CW    = (N_W > RES_W) ? N_W : RES_W;
	localparam int DC_W  = $clog2(TW + 1);

	localparam logic [TW-1:0]    T_ONE = {1'b1, {F{1'b0}}};
	localparam logic [TOT_W-1:0] ROUND = TOT_W'(1) << (2 * F - 1);

	// per-curve state
	logic [COORD_W-1:0] pt_q [3][3];
	logic [COORD_W-1:0] prev_q [3];
	logic [N_W-1:0]     n_q;
	logic [N_W-1:0]     seg_cnt_q;
	logic [DC_W-1:0]    dcnt_q;
	logic [N_W-1:0]     drem_q;
	logic [TW-1:0]      quo_q;
	logic [N_W-1:0]     rem_q;
	logic [TW-1:0]      t_q;
	logic               seg_v_q;
	logic               seg_last_q;

	// pipeline
	logic               v_s1, v_s2, v_s3;
	logic               last_s1, last_s2, last_s3;
	logic [WW-1:0]      w_s1 [3];
	logic [AW-1:0]      prod_hi_s2 [3][3];
	logic [AW-1:0]      prod_lo_s2 [3][3];
	logic [AW-1:0]      sum_hi_s3 [3];
	logic [AW-1:0]      sum_lo_s3 [3];
	logic               out_v_q;

	logic [CW-1:0]      res_ext;
	logic [N_W-1:0]     n_c;
	logic               div_bit;
	logic [N_W:0]       div_trial;
	logic               div_ge;
	logic [N_W-1:0]     div_rem_nx;
	logic [N_W:0]       step_sum;
	logic               step_ge;
	logic [N_W-1:0]     rem_nx;
	logic [TW-1:0]      t_nx;
	logic [TW-1:0]      u_c;
	logic [WW-1:0]      w_c [3];
	logic [TOT_W-1:0]   total_c [3];
	logic [COORD_W-1:0] res_c [3];
	logic               adv;

	// segment count clamped to one..MAX_SEGMENTS
	always_comb begin
		res_ext = CW'(resolution);
		if (res_ext == '0) begin
			n_c = N_W'(1);
		end else if (res_ext > CW'(MAX_SEGMENTS)) begin
			n_c = N_W'(MAX_SEGMENTS);
		end else begin
			n_c = N_W'(res_ext);
		end
	end

	// restoring divide of one (2^F) by n, one quotient bit a cycle
	always_comb begin
		div_bit    = (dcnt_q == '0);
		div_trial  = {drem_q, div_bit};
		div_ge     = (div_trial >= {1'b0, n_q});
		div_rem_nx = div_ge ? N_W'(div_trial - {1'b0, n_q}) : N_W'(div_trial);
	end

	// t advances by the quotient, plus one when the remainder wraps
	always_comb begin
		step_sum = {1'b0, rem_q} + {1'b0, drem_q};
		step_ge  = (step_sum >= {1'b0, n_q});
		rem_nx   = step_ge ? N_W'(step_sum - {1'b0, n_q}) : N_W'(step_sum);
		t_nx     = t_q + quo_q + TW'(step_ge);
	end

	always_comb begin
		u_c    = T_ONE - t_q;
		w_c[0] = WW'(u_c) * WW'(u_c);
		w_c[1] = (WW'(u_c) * WW'(t_q)) << 1;
		w_c[2] = WW'(t_q) * WW'(t_q);
	end

	// recombine halves, round to nearest and drop the offset
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			total_c[k] = {sum_hi_s3[k], {HW{1'b0}}} + TOT_W'(sum_lo_s3[k]) + ROUND;
			res_c[k]   = total_c[k][TOT_W-1 -: COORD_W] ^ SIGN_BIT;
		end
	end

	assign adv = !out_v_q || out_ready;

	always_comb begin
		status.div_done   = (dcnt_q == DC_W'(TW));
		status.issue_last = (seg_cnt_q == n_q - N_W'(1));
		status.adv        = adv;
		status.pipe_empty = !(seg_v_q || v_s1 || v_s2 || v_s3 || out_v_q);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q       <= '0;
			seg_cnt_q <= '0;
			dcnt_q    <= '0;
			seg_v_q   <= 1'b0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			if (cmd.load) begin
				n_q       <= n_c;
				seg_cnt_q <= '0;
				dcnt_q    <= '0;
			end
			if (cmd.div_step) begin
				dcnt_q <= dcnt_q + DC_W'(1);
			end
			if (cmd.seg_step) begin
				seg_cnt_q <= seg_cnt_q + N_W'(1);
			end
			if (adv) begin
				seg_v_q <= cmd.seg_step;
				v_s1    <= seg_v_q;
				v_s2    <= v_s1;
				v_s3    <= v_s2;
				out_v_q <= v_s3;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int j = 0; j < 3; j++) begin
				for (int k = 0; k < 3; k++) begin
					pt_q[j][k] <= ((k == 2 && !mode) ? '0 : ctl_pts[j][k]) ^ SIGN_BIT;
				end
			end
			for (int k = 0; k < 3; k++) begin
				prev_q[k] <= (k == 2 && !mode) ? '0 : ctl_pts[0][k];
			end
			drem_q <= '0;
			quo_q  <= '0;
			rem_q  <= N_W'(n_c >> 1);
			t_q    <= '0;
		end
		if (cmd.div_step) begin
			drem_q <= div_rem_nx;
			quo_q  <= {quo_q[TW-2:0], div_ge};
		end
		if (cmd.seg_step) begin
			rem_q <= rem_nx;
			t_q   <= t_nx;
		end
		if (adv) begin
			seg_last_q <= status.issue_last;
			last_s1    <= seg_last_q;
			last_s2    <= last_s1;
			last_s3    <= last_s2;
			for (int j = 0; j < 3; j++) begin
				w_s1[j] <= w_c[j];
			end
			for (int k = 0; k < 3; k++) begin
				for (int j = 0; j < 3; j++) begin
					prod_hi_s2[k][j] <= AW'(w_s1[j]) * AW'(pt_q[j][k][COORD_W-1:HW]);
					prod_lo_s2[k][j] <= AW'(w_s1[j]) * AW'(pt_q[j][k][HW-1:0]);
				end
				sum_hi_s3[k] <= prod_hi_s2[k][0] + prod_hi_s2[k][1] + prod_hi_s2[k][2];
				sum_lo_s3[k] <= prod_lo_s2[k][0] + prod_lo_s2[k][1] + prod_lo_s2[k][2];
			end
			if (v_s3) begin
				seg_last <= last_s3;
				for (int k = 0; k < 3; k++) begin
					seg_start[k] <= prev_q[k];
					seg_end[k]   <= res_c[k];
					prev_q[k]    <= res_c[k];
				end
			end
		end
	end

	assign out_valid = out_v_q;

endmodule

// ----- hw/rtl/quadratic_bezier_segment_generator.sv -----
// a curve item is taken only while idle; the serial divide of one by the segment count runs
// first, then one segment item a cycle while the output is not stalled; the next curve item
// is taken only after the segment stream of the previous one has drained from the pipeline,
// and output stalls hold the segment stream
// reset: arst_n asynchronous, active low; resolution returns to 50, control state clears
module quadratic_bezier_segment_generator import qbz_pkg::*; #(
	parameter int MAX_SEGMENTS  = 64,
	parameter int FRACTION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// item channels
	qbz_in_if.sink      in_ch,
	qbz_out_if.source   out_ch
);

	logic [RES_W-1:0]             res_q;
	logic                         reg_sel;
	qbz_cmd_t                     cmd;
	qbz_status_t                  status;
	logic [2:0][2:0][COORD_W-1:0] ctl_pts;
	logic [2:0][COORD_W-1:0]      seg_start;
	logic [2:0][COORD_W-1:0]      seg_end;

	// register file: one word, picked by address bit 2; byte offset bits are ignored
	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == REG_RESOLUTION);
	assign prdata  = reg_sel ? 32'(res_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= RES_RESET;
		end else if (psel && penable && pwrite && reg_sel) begin
			res_q <= pwdata[RES_W-1:0];
		end
	end

	// control points as [point][axis]
	assign ctl_pts[0][0] = in_ch.p0_x;
	assign ctl_pts[0][1] = in_ch.p0_y;
	assign ctl_pts[0][2] = in_ch.p0_z;
	assign ctl_pts[1][0] = in_ch.p1_x;
	assign ctl_pts[1][1] = in_ch.p1_y;
	assign ctl_pts[1][2] = in_ch.p1_z;
	assign ctl_pts[2][0] = in_ch.p2_x;
	assign ctl_pts[2][1] = in_ch.p2_y;
	assign ctl_pts[2][2] = in_ch.p2_z;

	// controller: idle, divide, issue segments, drain the pipeline
	qbz_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.status   (status),
		.cmd      (cmd)
	);

	// datapath: step divider, t stepping, bernstein weights, blend and round, output register
	qbz_datapath #(
		.MAX_SEGMENTS  (MAX_SEGMENTS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.resolution (res_q),
		.mode       (in_ch.mode),
		.ctl_pts    (ctl_pts),
		.out_ready  (out_ch.ready),
		.out_valid  (out_ch.valid),
		.seg_start  (seg_start),
		.seg_end    (seg_end),
		.seg_last   (out_ch.last_segment)
	);

	assign out_ch.start_x = seg_start[0];
	assign out_ch.start_y = seg_start[1];
	assign out_ch.start_z = seg_start[2];
	assign out_ch.end_x   = seg_end[0];
	assign out_ch.end_y   = seg_end[1];
	assign out_ch.end_z   = seg_end[2];

endmodule

// ----- hw/rtl/qbz_checker.sv -----
// port-level checks of the segment generator, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module qbz_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic out_last
);

	// a curve is only taken once all segments of the previous one are gone
	`QBZ_NEVER(a_no_take_while_busy, clk, arst_n, in_valid && in_ready && out_valid, "curve taken while segments pending")

	// the block is busy right after taking a curve
	`QBZ_ASSERT(a_busy_after_take, clk, arst_n, in_valid && in_ready |=> !in_ready, "ready stayed high after a curve was taken")

	// nothing follows the final segment of a curve
	`QBZ_ASSERT(a_last_ends_curve, clk, arst_n, out_valid && out_ready && out_last |=> !out_valid, "segment item after the final one")

	// a stalled result stays offered
	`QBZ_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid, "output valid dropped while stalled")

endmodule

bind quadratic_bezier_segment_generator qbz_checker u_qbz_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_last  (out_ch.last_segment)
);
